// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers; clk and rst are taken from the scope of the use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TCW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcw check failed");

// Next-cycle implication.
`define TCW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcw check failed");

// Checked even while reset is high.
`define TCW_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("tcw check failed");

`endif

// ----- hw/rtl/tcw_pkg.sv -----
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int CELL_W  = 11;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int VALUE_W = 16;

  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int CNT_W   = $clog2(CELLS + 1);
  localparam int CUR_W   = CELL_W + 1;

  localparam int ESC_W   = 3;
  localparam int ESC_MAX = 4;

  localparam int CURSOR_RESET = (10 % ROWS) * COLUMNS;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  localparam logic OP_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CH_LF      = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BS      = 8'd8;
  localparam logic [CHAR_W-1:0] CH_ESC     = 8'd27;
  localparam logic [CHAR_W-1:0] CH_BRACKET = 8'h5B;

  // Queue depth; pointers wrap explicitly so any depth works.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef logic [2:0] kind_t;
  localparam kind_t KIND_READ    = 3'd0;
  localparam kind_t KIND_LF      = 3'd1;
  localparam kind_t KIND_BS      = 3'd2;
  localparam kind_t KIND_ESC     = 3'd3;
  localparam kind_t KIND_BRACKET = 3'd4;
  localparam kind_t KIND_PLAIN   = 3'd5;

  typedef struct packed {
    logic              operation;
    logic [CHAR_W-1:0] char_code;
    logic [CELL_W-1:0] cell_index;
  } cmd_beat_t;

  typedef struct packed {
    logic [VALUE_W-1:0] cell_value;
    logic [CELL_W-1:0]  cursor_cell;
    logic               escape_active;
  } res_beat_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] char_code;
    logic [CELL_W-1:0] cell_index;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_flags_t;

endpackage

// ----- hw/rtl/tcw_ram.sv -----
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/tcw_front.sv -----
module tcw_front import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_beat_t cmd,
  input  logic      clearing,
  input  q_flags_t  q,
  output logic      push,
  output item_t     item
);

  logic  held;
  logic  accept;
  kind_t kind;

  always_comb begin
    if (cmd.operation == OP_READ) begin
      kind = KIND_READ;
    end else begin
      unique case (cmd.char_code)
        CH_LF:      kind = KIND_LF;
        CH_BS:      kind = KIND_BS;
        CH_ESC:     kind = KIND_ESC;
        CH_BRACKET: kind = KIND_BRACKET;
        default:    kind = KIND_PLAIN;
      endcase
    end
  end

  assign push      = held && !q.full;
  assign cmd_stall = clearing || (held && q.full);
  assign accept    = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.kind       <= kind;
      item.char_code  <= cmd.char_code;
      item.cell_index <= cmd.cell_index;
    end
  end

endmodule

// ----- hw/rtl/tcw_fifo.sv -----
module tcw_fifo import tcw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  item_t    wr_item,
  input  logic     pop,
  output item_t    head,
  output q_flags_t q
);

  item_t            slots [Q_DEPTH];
  logic [Q_AW-1:0]  wptr;
  logic [Q_AW-1:0]  rptr;
  logic [Q_CW-1:0]  count;

  assign q.full  = (count == Q_CW'(Q_DEPTH));
  assign q.empty = (count == '0);
  assign head    = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_item;
    end
  end

endmodule

// ----- hw/rtl/tcw_back.sv -----
module tcw_back import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [ATTR_W-1:0] cfg_data,
  input  item_t             head,
  input  q_flags_t          q,
  output logic              pop,
  output logic              clearing,
  output logic              res_valid,
  input  logic              res_stall,
  output res_beat_t         res
);

  localparam logic [1:0] ST_INIT   = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SCROLL = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0]          state, state_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [CELL_W-1:0]   cursor, cursor_next;
  logic [COL_W-1:0]    col, col_next;
  logic [ESC_W-1:0]    esc, esc_next;
  logic [ATTR_W-1:0]   attr;
  logic                rd_hit, rd_hit_next;
  logic                res_valid_next;
  res_beat_t           res_next;

  logic                we, re;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [VALUE_W-1:0]  wdata, rdata;

  tcw_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign clearing = (state == ST_INIT);

  always_comb begin
    logic [CUR_W-1:0] cur_ext;
    logic             swallow;

    state_next     = state;
    cnt_next       = cnt;
    cursor_next    = cursor;
    col_next       = col;
    esc_next       = esc;
    rd_hit_next    = rd_hit;
    res_valid_next = res_valid;
    res_next       = res;
    pop            = 1'b0;
    we             = 1'b0;
    waddr          = '0;
    wdata          = '0;
    re             = 1'b0;
    raddr          = '0;
    cur_ext        = CUR_W'(cursor);
    swallow        = 1'b0;

    if (res_valid && !res_stall) begin
      res_valid_next = 1'b0;
    end

    unique case (state)
      ST_INIT: begin
        // zero the screen one cell a cycle
        we       = 1'b1;
        waddr    = ADDR_W'(cnt);
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(CELLS - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (!q.empty) begin
          pop         = 1'b1;
          state_next  = ST_RESULT;
          rd_hit_next = 1'b0;
          if (head.kind == KIND_READ) begin
            rd_hit_next = (head.cell_index < CELL_W'(CELLS));
            re          = 1'b1;
            raddr       = ADDR_W'(head.cell_index);
          end else begin
            // escape sequence: '[' must follow ESC, then up to two more bytes
            swallow = (esc != '0) && (esc < ESC_W'(ESC_MAX)) &&
                      !((esc == ESC_W'(1)) && (head.kind != KIND_BRACKET));
            if (swallow) begin
              esc_next = esc + 1'b1;
            end else begin
              case (head.kind)
                KIND_LF: begin
                  cur_ext  = CUR_W'(cursor) - CUR_W'(col) + CUR_W'(COLUMNS);
                  col_next = '0;
                end
                KIND_BS: begin
                  if (cursor != '0) begin
                    cur_ext  = CUR_W'(cursor) - 1'b1;
                    col_next = (col == '0) ? COL_W'(COLUMNS - 1) : col - 1'b1;
                  end
                end
                KIND_ESC: begin
                  esc_next = (esc != '0) ? ESC_W'(0) : ESC_W'(1);
                end
                default: begin
                  we       = 1'b1;
                  waddr    = ADDR_W'(cursor);
                  wdata    = {attr, head.char_code};
                  cur_ext  = CUR_W'(cursor) + 1'b1;
                  col_next = (col == COL_W'(COLUMNS - 1)) ? '0 : col + 1'b1;
                end
              endcase
            end
            if (cur_ext >= CUR_W'(CELLS)) begin
              cursor_next = CELL_W'(cur_ext - CUR_W'(COLUMNS));
              cnt_next    = '0;
              state_next  = ST_SCROLL;
            end else begin
              cursor_next = CELL_W'(cur_ext);
            end
          end
        end
      end

      ST_SCROLL: begin
        // read cell cnt+COLUMNS, write it back one row up in the next cycle;
        // the bottom row is written with zero
        if (cnt < CNT_W'(CELLS - COLUMNS)) begin
          re    = 1'b1;
          raddr = ADDR_W'(cnt + CNT_W'(COLUMNS));
        end
        if (cnt != '0) begin
          we    = 1'b1;
          waddr = ADDR_W'(cnt - 1'b1);
          wdata = (cnt <= CNT_W'(CELLS - COLUMNS)) ? rdata : '0;
        end
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(CELLS)) begin
          cnt_next   = '0;
          state_next = ST_RESULT;
        end
      end

      ST_RESULT: begin
        if (!res_valid || !res_stall) begin
          res_valid_next         = 1'b1;
          res_next.cell_value    = rd_hit ? rdata : '0;
          res_next.cursor_cell   = cursor;
          res_next.escape_active = (esc != '0);
          state_next             = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      cnt       <= '0;
      cursor    <= CELL_W'(CURSOR_RESET);
      col       <= '0;
      esc       <= '0;
      attr      <= ATTR_RESET;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      cursor    <= cursor_next;
      col       <= col_next;
      esc       <= esc_next;
      res_valid <= res_valid_next;
      if (cfg_we) begin
        attr <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_hit <= rd_hit_next;
    res    <= res_next;
  end

endmodule

// ----- hw/rtl/text_console_char_writer_top.sv -----
// Text console character writer: an 80x25 screen of 16-bit cells (attribute
// high byte, character low byte), a cursor and an escape counter.
// cmd channel (cmd_valid/cmd_stall/cmd): one beat per item, either a put of
//   char_code or a read of cell_index.
// res channel (res_valid/res_stall/res): exactly one beat per item, in order,
//   carrying the read cell (zero for a put), the cursor and escape state.
// cfg_we/cfg_data write the attribute used for new characters; write only
//   while no item is in flight.
// Path: the front register, the queue, the engine's decode state and the
//   result register, in that order.
// The engine finishes one item (decode and screen RAM access, then the
//   result register load) before it takes the next.
// A scroll copies the screen through the single RAM port pair.
// Reset: synchronous. Afterwards the screen RAM is cleared one cell a cycle,
//   with cmd_stall high; attribute returns to 0x07 and the cursor to the
//   start of row ten.
// Receiver stall: the result register holds; the engine waits, the two-entry
//   queue and the front register fill, then cmd_stall rises.
module text_console_char_writer_top import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  cmd_beat_t         cmd,
  output logic              res_valid,
  input  logic              res_stall,
  output res_beat_t         res,
  input  logic              cfg_we,
  input  logic [ATTR_W-1:0] cfg_data
);

  q_flags_t q;
  item_t    front_item;
  item_t    head;
  logic     push;
  logic     pop;
  logic     clearing;

  // front: register and classify each beat
  tcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .clearing  (clearing),
    .q         (q),
    .push      (push),
    .item      (front_item)
  );

  // short queue decoupling front from the engine
  tcw_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (front_item),
    .pop     (pop),
    .head    (head),
    .q       (q)
  );

  // engine: screen RAM, cursor, escape handling, scroll, result register
  tcw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .head      (head),
    .q         (q),
    .pop       (pop),
    .clearing  (clearing),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// ----- hw/rtl/tcw_checker.sv -----
`include "assert_macros.svh"

module tcw_checker import tcw_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              cmd_stall,
  input logic              res_valid,
  input logic              res_stall,
  input res_beat_t         res
);

  // cursor never points past the last cell
  `TCW_ASSERT_IMP(a_cursor_range, res_valid, res.cursor_cell < CELL_W'(CELLS))

  // a stalled result holds
  `TCW_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))

  // no result straight out of reset
  `TCW_ASSERT_IMP(a_no_res_after_rst, $past(rst), !res_valid)

  // screen clear follows reset, input held off
  `TCW_ASSERT_ALWAYS(a_clear_stall, $past(rst) && !rst, cmd_stall)

endmodule

bind text_console_char_writer_top tcw_checker u_chk (.*);

// ----- bench/console_shadow_checker.sv -----
// Shadow model of the console: follows every accepted command beat, predicts
// its result beat and compares it with what the block returns.
module console_shadow_checker import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  logic              cmd_stall,
  input  cmd_beat_t         cmd,
  input  logic              res_valid,
  input  logic              res_stall,
  input  res_beat_t         res,
  input  logic              cfg_we,
  input  logic [ATTR_W-1:0] cfg_data,
  output int                mismatches,
  output int                awaited,
  output int                beats,
  output int                scrolls,
  output int                swallowed,
  output int                home_backspaces
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [VALUE_W-1:0] screen [CELLS];
  int unsigned        cursor;
  int unsigned        esc_count;
  logic [ATTR_W-1:0]  attribute;
  res_beat_t          awaited_results [$];

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s: got %0h, expected %0h (beat %0d)", what, got, want,
             beats - awaited_results.size());
    mismatches++;
  endtask

  // Applies one command beat to the shadow state, returns the result beat.
  function automatic res_beat_t advance_console(input cmd_beat_t b);
    res_beat_t         r;
    logic [CHAR_W-1:0] ch;
    bit                quiet;
    r     = '0;
    ch    = b.char_code;
    quiet = 1'b0;
    if (b.operation == OP_READ) begin
      if (b.cell_index < CELLS) r.cell_value = screen[b.cell_index];
    end else begin
      if (esc_count != 0 && esc_count < ESC_MAX &&
          !(esc_count == 1 && ch != CH_BRACKET)) begin
        esc_count++;
        swallowed++;
        quiet = 1'b1;
      end else if (ch == CH_LF) begin
        cursor = cursor - (cursor % COLUMNS) + COLUMNS;
      end else if (ch == CH_BS) begin
        if (cursor != 0) cursor--;
        else home_backspaces++;
      end else if (ch == CH_ESC) begin
        if (esc_count != 0) begin
          esc_count = 0;
          quiet = 1'b1;
        end else begin
          esc_count = 1;
        end
      end else begin
        if (cursor < CELLS) screen[cursor] = {attribute, ch};
        cursor++;
      end
      if (!quiet && cursor >= CELLS) begin
        for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = '0;
        cursor -= COLUMNS;
        scrolls++;
      end
    end
    r.cursor_cell   = cursor[CELL_W-1:0];
    r.escape_active = (esc_count != 0);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_beat_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) screen[i] = '0;
      cursor    = CURSOR_RESET;
      esc_count = 0;
      attribute = ATTR_RESET;
      awaited_results.delete();
    end else begin
      if (cfg_we) attribute = cfg_data;
      if (res_valid && !res_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result beat with nothing awaited", 32'(res), 0);
        end else begin
          want = awaited_results.pop_front();
          if (res.cell_value !== want.cell_value)
            report_mismatch("cell_value", 32'(res.cell_value), 32'(want.cell_value));
          if (res.cursor_cell !== want.cursor_cell)
            report_mismatch("cursor_cell", 32'(res.cursor_cell), 32'(want.cursor_cell));
          if (res.escape_active !== want.escape_active)
            report_mismatch("escape_active", 32'(res.escape_active),
                            32'(want.escape_active));
        end
      end
      if (cmd_valid && !cmd_stall) begin
        awaited_results.push_back(advance_console(cmd));
        beats++;
      end
    end
    awaited <= awaited_results.size();
  end

endmodule

// ----- bench/text_console_char_writer_top_tb.sv -----
// Stimulus and verdict for the console engine; result checking sits in the
// shadow checker instantiated beside the block.
module text_console_char_writer_top_tb;
  import tcw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_PUT      = 1'b0;
  localparam int   INDEX_MAX   = (1 << CELL_W) - 1;
  // Receiver hold-off long enough to fill the queue and stall the command side.
  localparam int   HOLD_CYCLES = 300;
  // Slowest quiet stretch: the clear after reset, or a scroll on top of a
  // receiver stall burst, or the hold-off; taken well over.
  localparam int   QUIET_LIMIT = 12000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cmd_valid = 1'b0;
  logic              cmd_stall;
  cmd_beat_t         cmd = '0;
  logic              res_valid;
  logic              res_stall;
  res_beat_t         res;
  logic              cfg_we = 1'b0;
  logic [ATTR_W-1:0] cfg_data = ATTR_RESET;

  int mismatches, awaited, beats, scrolls, swallowed, home_backspaces;
  int quiet_cycles = 0;
  int attr_writes  = 0;
  int holds_done   = 0;
  bit idle_on      = 1'b1;   // random gaps on both sides
  bit hold_req     = 1'b0;   // ask the receiver for one long hold-off

  text_console_char_writer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  console_shadow_checker shadow (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_valid),
    .cmd_stall       (cmd_stall),
    .cmd             (cmd),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .res             (res),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .awaited         (awaited),
    .beats           (beats),
    .scrolls         (scrolls),
    .swallowed       (swallowed),
    .home_backspaces (home_backspaces)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: any accepted beat on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, and no
  // stalls at all once idling is switched off for the closing stretch.
  initial begin : receiver
    int n;
    res_stall = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_stall <= 1'b1;
        n = 0;
        while (n < HOLD_CYCLES) begin
          @(posedge clk);
          n++;
        end
        holds_done++;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        res_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // One command beat; returns at the edge that accepts it, with valid still
  // high so the next beat can follow back to back. A gap, when taken, lowers
  // valid before the beat is offered.
  task automatic send_beat(input logic op, input logic [CHAR_W-1:0] ch,
                           input logic [CELL_W-1:0] idx);
    cmd_beat_t b;
    b.operation  = op;
    b.char_code  = ch;
    b.cell_index = idx;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= b;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  // Puts carry a random cell index and reads a random byte, so the unused
  // field toggles too.
  task automatic put_byte(input logic [CHAR_W-1:0] ch);
    send_beat(OP_PUT, ch, CELL_W'($urandom_range(0, INDEX_MAX)));
  endtask

  task automatic read_cell(input int idx);
    send_beat(OP_READ, CHAR_W'($urandom_range(0, 255)), CELL_W'(idx));
  endtask

  // Stop offering and wait until every result beat has come back.
  task automatic drain();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic settle_and_set(input logic [ATTR_W-1:0] attr);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= attr;
    @(posedge clk);
    cfg_we   <= 1'b0;
    attr_writes++;
  endtask

  // One random fragment of console traffic. Most of it is text and proper
  // escape sequences; the rest is broken sequences, reads, backspace runs and raw noise.
  task automatic random_burst();
    int                kind, n, lf_pct;
    logic [CHAR_W-1:0] ch;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      // text run; a third of the runs have no line feeds, so long runs wrap the row
      n      = $urandom_range(1, 90);
      lf_pct = ($urandom_range(0, 2) == 0) ? 0 : 8;
      repeat (n) begin
        if ($urandom_range(0, 99) < lf_pct) put_byte(CH_LF);
        else put_byte(CHAR_W'($urandom_range(8'h20, 8'h7E)));
      end
    end else if (kind < 55) begin
      // ESC [ with two parameter bytes swallowed, then bytes handled at count 4
      put_byte(CH_ESC);
      put_byte(CH_BRACKET);
      put_byte(CHAR_W'($urandom_range(0, 255)));
      put_byte(CHAR_W'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 3)) put_byte(CHAR_W'($urandom_range(0, 255)));
    end else if (kind < 63) begin
      put_byte(CH_ESC);
      case ($urandom_range(0, 3))
        0: begin
          // no bracket: the byte is handled normally, escape stays armed unless it is another ESC
          ch = CHAR_W'($urandom_range(0, 255));
          if (ch == CH_BRACKET) ch = CH_LF;
          put_byte(ch);
        end
        1: put_byte(CH_ESC);
        2: begin
          put_byte(CH_BRACKET);
          put_byte(CH_ESC);
        end
        default: begin
          put_byte(CH_BRACKET);
          repeat (3) put_byte(CHAR_W'($urandom_range(0, 255)));
          put_byte(CH_ESC);
        end
      endcase
    end else if (kind < 83) begin
      repeat ($urandom_range(1, 4)) begin
        n = $urandom_range(0, 9);
        if (n < 6) read_cell($urandom_range(0, CELLS - 1));
        else if (n < 8) read_cell($urandom_range(CELLS - COLUMNS, CELLS - 1));
        else if (n < 9) read_cell($urandom_range(CELLS, INDEX_MAX));
        else read_cell($urandom_range(0, COLUMNS - 1));
      end
    end else if (kind < 91) begin
      repeat ($urandom_range(1, 6)) put_byte(CH_BS);
    end else begin
      repeat ($urandom_range(1, 5)) put_byte(CHAR_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int                p, n, target;
    logic [ATTR_W-1:0] attr;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset attribute and cursor, field extremes, controls and
    // every escape corner. The block clears its RAM first, so the first beat
    // waits out the clear.
    read_cell(0);
    read_cell(INDEX_MAX);            // past the last cell reads as zero
    read_cell(CELLS - 1);
    put_byte(8'h41);
    put_byte(8'h00);
    put_byte(8'hFF);
    read_cell(CURSOR_RESET);
    read_cell(CURSOR_RESET + 2);
    put_byte(CH_LF);
    put_byte(CH_BS);
    put_byte(CH_ESC);
    put_byte(CH_BRACKET);
    put_byte(8'h31);
    put_byte(8'h6D);
    put_byte(8'h7A);                 // count at four: written normally
    put_byte(CH_ESC);                // leaves escape mode from count four
    put_byte(CH_ESC);
    put_byte(8'h51);                 // no bracket after ESC: plain put
    put_byte(CH_ESC);                // leaves escape mode from count one
    put_byte(CH_ESC);
    put_byte(CH_BRACKET);
    put_byte(CH_ESC);                // swallowed at count two
    put_byte(CH_ESC);                // swallowed at count three
    put_byte(CH_ESC);                // clears at count four
    read_cell(CURSOR_RESET + COLUMNS - 1);

    // Rub-out: backspace from the middle of the screen down to the home cell
    // and past it, with the odd read mixed in.
    settle_and_set(8'hFF);
    repeat (920) begin
      n = $urandom_range(0, 99);
      if (n < 98) put_byte(CH_BS);
      else read_cell($urandom_range(0, INDEX_MAX));
    end

    // Line feeds from the top row run the cursor past the last cell, so the
    // screen scrolls and the cursor ends on the bottom row.
    repeat (27) put_byte(CH_LF);

    // Random phases, a fresh attribute each; the second opens with the long
    // receiver hold-off and the last runs with no idling on either side.
    for (p = 0; p < 6; p++) begin
      case (p)
        0:       attr = 8'h00;
        2:       attr = 8'h80;
        4:       attr = 8'hFF;
        default: attr = ATTR_W'($urandom_range(0, 255));
      endcase
      settle_and_set(attr);
      if (p == 1) hold_req = 1'b1;
      if (p == 5) idle_on = 1'b0;
      target = beats + ((p == 5) ? 25 : 30);
      while (beats < target) random_burst();
    end

    drain();
    repeat (8) @(posedge clk);

    $display("Run covered %0d beats with %0d scrolls, %0d escape bytes swallowed",
             beats, scrolls, swallowed);
    $display("and %0d backspaces at the home cell; %0d attribute writes, %0d hold-offs.",
             home_backspaces, attr_writes, holds_done);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_fifo.sv
hw/rtl/tcw_back.sv
hw/rtl/text_console_char_writer_top.sv
hw/rtl/tcw_checker.sv
bench/console_shadow_checker.sv
bench/text_console_char_writer_top_tb.sv
